// ===== rtl/xrd_pkg.sv =====
// Shared types and constants for the descrambling run-length byte decoder.
`timescale 1ns / 1ps

package xrd_pkg;

    // Byte and register widths.
    localparam int BYTE_W        = 8;
    localparam int ORIG_SIZE_W   = 24;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_INDEX_W   = 2;

    // Default width of the unpacked byte counter.
    localparam int SIZE_BITS_DEF = 24;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH   = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_XOR_KEY         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSED_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGINAL_SIZE   = 2'd2;

    // One decoded command handed from the front part to the back part.
    typedef struct packed {
        logic              clear;   // start of file: reset the byte count first
        logic [BYTE_W-1:0] value;   // unpacked byte value
        logic [BYTE_W-1:0] copies;  // requested copies, zero means none
    } cmd_t;

endpackage

// ===== rtl/xrd_front.sv =====
// Front part: descrambles each packed item and classifies it as a value or count byte.
`timescale 1ns / 1ps

module xrd_front
    import xrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] xor_key,
    input  logic              compressed_mode,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] packed_byte,
    input  logic              start_of_file,
    input  logic              queue_full,
    output logic              in_ready,
    output logic              push,
    output cmd_t              cmd
);

    logic [BYTE_W-1:0] prev_value_reg;
    logic [BYTE_W-1:0] prev_value_next;
    logic              have_prev_reg;
    logic              have_prev_next;
    logic              expect_count_reg;
    logic              expect_count_next;

    logic [BYTE_W-1:0] descrambled;
    logic [BYTE_W-1:0] prev_eff;
    logic              have_prev_eff;
    logic              expect_eff;

    // An item is taken whenever the queue has room.
    assign in_ready    = !queue_full;
    assign push        = in_valid && in_ready;
    assign descrambled = packed_byte ^ xor_key;

    // Start of file clears the stream state before the item is handled.
    assign prev_eff      = start_of_file ? '0   : prev_value_reg;
    assign have_prev_eff = start_of_file ? 1'b0 : have_prev_reg;
    assign expect_eff    = start_of_file ? 1'b0 : expect_count_reg;

    // Classify the item and work out the next stream state.
    always_comb
    begin
        prev_value_next   = prev_value_reg;
        have_prev_next    = have_prev_reg;
        expect_count_next = expect_count_reg;
        cmd.clear         = start_of_file;
        cmd.value         = descrambled;
        cmd.copies        = BYTE_W'(1);
        if (compressed_mode && expect_eff)
        begin
            // Count byte: further copies of the previous value.
            cmd.value         = prev_eff;
            cmd.copies        = descrambled;
            prev_value_next   = prev_eff;
            have_prev_next    = have_prev_eff;
            expect_count_next = 1'b0;
        end
        else
        begin
            // Value byte: a repeat of the previous value announces a count byte.
            expect_count_next = compressed_mode && have_prev_eff &&
                                (descrambled == prev_eff);
            prev_value_next   = descrambled;
            have_prev_next    = 1'b1;
        end
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_value_reg   <= '0;
            have_prev_reg    <= 1'b0;
            expect_count_reg <= 1'b0;
        end
        else if (push)
        begin
            prev_value_reg   <= prev_value_next;
            have_prev_reg    <= have_prev_next;
            expect_count_reg <= expect_count_next;
        end
    end

endmodule

// ===== rtl/xrd_queue.sv =====
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module xrd_queue
    import xrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // A write into a full queue or a read from an empty one would lose or invent an item.
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue read while empty");

endmodule

// ===== rtl/xrd_back.sv =====
// Back part: counts unpacked bytes, cuts runs at the original size and holds the result.
`timescale 1ns / 1ps

module xrd_back
    import xrd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ORIG_SIZE_W-1:0] original_size,
    input  logic                   queue_empty,
    input  cmd_t                   head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BYTE_W-1:0]      out_value,
    output logic [BYTE_W-1:0]      repeat_count,
    output logic                   last
);

    logic [SIZE_BITS-1:0] emitted_reg;
    logic [SIZE_BITS-1:0] emitted_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BYTE_W-1:0]    out_value_reg;
    logic [BYTE_W-1:0]    repeat_count_reg;
    logic [BYTE_W-1:0]    repeat_count_next;
    logic                 last_reg;
    logic                 last_next;

    logic [SIZE_BITS-1:0] limit;
    logic [SIZE_BITS-1:0] base;
    logic [SIZE_BITS-1:0] left;
    logic [SIZE_BITS-1:0] copies_wide;
    logic                 emit_ok;

    // The size limit is counted in the counter width.
    assign limit       = SIZE_BITS'(original_size);
    assign base        = head.clear ? '0 : emitted_reg;
    assign left        = limit - base;
    assign copies_wide = SIZE_BITS'(head.copies);
    assign emit_ok     = (head.copies != '0) && (base < limit);

    // A command is taken once the output register is free or being emptied.
    assign pop = !queue_empty && (!out_valid_reg || out_ready);

    // Cut the run to what is left of the file and advance the byte count.
    always_comb
    begin
        repeat_count_next = head.copies;
        last_next         = 1'b0;
        emitted_next      = emitted_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (copies_wide >= left)
        begin
            repeat_count_next = left[BYTE_W-1:0];
            last_next         = 1'b1;
        end
        if (pop)
        begin
            out_valid_next = emit_ok;
            emitted_next   = emit_ok ? base + SIZE_BITS'(repeat_count_next) : base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded only when a command is taken.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_value_reg    <= head.value;
            repeat_count_reg <= repeat_count_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign repeat_count = repeat_count_reg;
    assign last         = last_reg;

    // A held result never reports zero copies.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> repeat_count_reg != '0)
        else $error("result with zero copies");
    // The byte count never passes the size while a result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> emitted_reg <= limit)
        else $error("byte count beyond original size");
    // A result flagged last leaves the count exactly at the size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> emitted_reg == limit)
        else $error("last result does not end at original size");

endmodule

// ===== rtl/xor_rle_byte_decoder_unit.sv =====
// Top level of the descrambling doubled-byte run-length decoder.
`timescale 1ns / 1ps

// Takes one packed byte per cycle while the command queue has room, XORs it
// with xor_key and, in compressed mode, decodes doubled-byte runs: a byte equal
// to the one before it is sent and makes the next byte a count of further
// copies, which leave as one item with repeat_count copies (a count of zero
// gives no item). Output stops at original_size unpacked bytes, and the item
// that reaches it is cut short and flagged last. A two-entry command queue
// between the classifying front part and the counting back part lets the input
// keep flowing for two items while the output stalls; results are held in an
// output register. The user must write configuration through cfg_we, cfg_index
// and cfg_data while idle; the block itself does not enforce this.
module xor_rle_byte_decoder_unit
    import xrd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      packed_byte,
    input  logic                   start_of_file,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [BYTE_W-1:0]      out_value,
    output logic [BYTE_W-1:0]      repeat_count,
    output logic                   last
);

    logic [BYTE_W-1:0]      xor_key_reg;
    logic                   compressed_mode_reg;
    logic [ORIG_SIZE_W-1:0] original_size_reg;

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    cmd_t push_cmd;
    cmd_t head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg         <= '0;
            compressed_mode_reg <= 1'b1;
            original_size_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_XOR_KEY:         xor_key_reg         <= cfg_data[BYTE_W-1:0];
                REG_COMPRESSED_MODE: compressed_mode_reg <= cfg_data[0];
                REG_ORIGINAL_SIZE:   original_size_reg   <= cfg_data[ORIG_SIZE_W-1:0];
                default:             ;
            endcase
        end
    end

    xrd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .xor_key         (xor_key_reg),
        .compressed_mode (compressed_mode_reg),
        .in_valid        (in_valid),
        .packed_byte     (packed_byte),
        .start_of_file   (start_of_file),
        .queue_full      (queue_full),
        .in_ready        (in_ready),
        .push            (push),
        .cmd             (push_cmd)
    );

    xrd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    xrd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .original_size (original_size_reg),
        .queue_empty   (queue_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_value     (out_value),
        .repeat_count  (repeat_count),
        .last          (last)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the descrambling doubled-byte run-length decoder.
`timescale 1ns / 1ps

module tb
    import xrd_pkg::*;
();

    // Expected decoder output item.
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] copies;
        logic              last;
    } byte_run_t;

    // Shadow decoder that predicts output items and checks the ones observed.
    class run_scoreboard;
        byte_run_t                runs_due[$];
        logic [BYTE_W-1:0]        key;
        logic                     compressed;
        logic [ORIG_SIZE_W-1:0]   orig_size;
        logic [BYTE_W-1:0]        prev_value;
        logic                     have_prev;
        logic                     count_next;
        logic [SIZE_BITS_DEF-1:0] emitted;
        int                       errors;
        int                       checked;
        int                       last_seen;
        int                       longest_run;

        function new();
            key         = '0;
            compressed  = 1'b1;
            orig_size   = '0;
            errors      = 0;
            checked     = 0;
            last_seen   = 0;
            longest_run = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            prev_value = '0;
            have_prev  = 1'b0;
            count_next = 1'b0;
            emitted    = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_XOR_KEY:         key        = data[BYTE_W-1:0];
                REG_COMPRESSED_MODE: compressed = data[0];
                REG_ORIGINAL_SIZE:   orig_size  = data[ORIG_SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Queue copies of a value, cut to what is left of the file size.
        function void queue_run(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] copies);
            logic [SIZE_BITS_DEF-1:0] left;
            byte_run_t                r;
            if (copies == 0 || emitted >= orig_size)
                return;
            left     = orig_size - emitted;
            r.value  = v;
            r.copies = copies;
            r.last   = 1'b0;
            if (SIZE_BITS_DEF'(copies) >= left)
            begin
                r.copies = left[BYTE_W-1:0];
                r.last   = 1'b1;
            end
            emitted = emitted + SIZE_BITS_DEF'(r.copies);
            runs_due.push_back(r);
        endfunction

        // Advance the shadow state by one accepted packed byte.
        function void note_item(logic [BYTE_W-1:0] pb, logic sof);
            logic [BYTE_W-1:0] b;
            b = pb ^ key;
            if (sof)
                clear_stream();
            if (compressed && count_next)
            begin
                count_next = 1'b0;
                queue_run(prev_value, b);
                return;
            end
            if (!compressed)
                count_next = 1'b0;
            else if (have_prev && b == prev_value)
                count_next = 1'b1;
            prev_value = b;
            have_prev  = 1'b1;
            queue_run(b, 8'd1);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one observed output item with the oldest expectation.
        task check_result(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] c, logic l);
            byte_run_t r;
            if (runs_due.size() == 0)
            begin
                report($sformatf("unexpected item value=%02h count=%0d last=%0b", v, c, l));
                return;
            end
            r = runs_due.pop_front();
            checked++;
            if (l)
                last_seen++;
            if (int'(c) > longest_run)
                longest_run = int'(c);
            if (v !== r.value || c !== r.copies || l !== r.last)
                report($sformatf("got value=%02h count=%0d last=%0b, wanted %02h %0d %0b",
                                 v, c, l, r.value, r.copies, r.last));
        endtask

        function int pending();
            return runs_due.size();
        endfunction
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      packed_byte   = '0;
    logic                   start_of_file = 1'b0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [BYTE_W-1:0]      out_value;
    logic [BYTE_W-1:0]      repeat_count;
    logic                   last;

    run_scoreboard     sb = new();
    logic [BYTE_W-1:0] cur_key       = '0;
    logic [BYTE_W-1:0] last_plain    = '0;
    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                hold_cycles   = 0;
    int                items_sent    = 0;
    int                files_run     = 0;

    xor_rle_byte_decoder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .packed_byte  (packed_byte),
        .start_of_file(start_of_file),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .repeat_count (repeat_count),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Watch both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_item(packed_byte, start_of_file);
            if (out_valid && out_ready)
                sb.check_result(out_value, repeat_count, last);
        end
    end

    // Output side: random stalls, plus an optional long hold-off.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hard limit on the run length.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        if (idx == REG_XOR_KEY)
            cur_key = data[BYTE_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one packed byte after a random gap and wait until it is taken.
    task send_item(logic [BYTE_W-1:0] pb, logic sof);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        packed_byte   <= pb;
        start_of_file <= sof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Send an unpacked byte, scrambled with the current key.
    task send_plain(logic [BYTE_W-1:0] v, logic sof);
        last_plain = v;
        send_item(v ^ cur_key, sof);
    endtask

    // Let the block run dry before touching the registers.
    task settle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected items never arrived", sb.pending()));
        repeat (10) @(posedge clk);
    endtask

    function logic [BYTE_W-1:0] pick_count();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (r < 5)
            return BYTE_W'($urandom_range(1, 6));
        return BYTE_W'($urandom_range(255));
    endfunction

    // Mostly well-formed literals and doubled-byte runs, with some noise.
    task run_file(int len, bit with_sof);
        int                n;
        int                r;
        logic [BYTE_W-1:0] v;
        n = 0;
        if (with_sof)
        begin
            send_plain(BYTE_W'($urandom_range(255)), 1'b1);
            n++;
        end
        while (n < len)
        begin
            r = $urandom_range(99);
            v = BYTE_W'($urandom_range(255));
            if (r < 50)
            begin
                send_plain(v, 1'b0);
                n++;
            end
            else if (r < 80)
            begin
                send_plain(v, 1'b0);
                send_plain(v, 1'b0);
                send_plain(pick_count(), 1'b0);
                n += 3;
            end
            else if (r < 90)
            begin
                send_item(v, 1'b0);
                n++;
            end
            else if (r < 95)
            begin
                send_plain(v, 1'b1);
                n++;
            end
            else
            begin
                send_plain(last_plain, 1'b0);
                n++;
            end
        end
    endtask

    function logic [CFG_DATA_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return CFG_DATA_W'($urandom_range(0, 200));
        if (r < 75)
            return CFG_DATA_W'($urandom_range(1, 8));
        if (r < 83)
            return '0;
        if (r < 92)
            return 24'hFFFFFF;
        return CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function logic [CFG_DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 24'h00;
        if (r == 1)
            return 24'hFF;
        if (r == 2)
            return 24'h95;
        return CFG_DATA_W'($urandom_range(255));
    endfunction

    // Main stimulus sequence.
    initial
    begin
        int random_items;
        int len;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: byte extremes, runs, zero count, cut-short last run.
        write_reg(REG_XOR_KEY, 24'h95);
        write_reg(REG_COMPRESSED_MODE, 24'd1);
        write_reg(REG_ORIGINAL_SIZE, 24'd20);
        send_plain(8'h00, 1'b1);
        send_plain(8'hFF, 1'b0);
        send_plain(8'h41, 1'b0);
        send_plain(8'h41, 1'b0);
        send_plain(8'd3, 1'b0);
        send_plain(8'h41, 1'b0);
        send_plain(8'd0, 1'b0);
        send_plain(8'h7E, 1'b0);
        send_plain(8'h7E, 1'b0);
        send_plain(8'd255, 1'b0);
        send_plain(8'h11, 1'b0);
        send_plain(8'h12, 1'b1);
        settle();

        // Directed: a zero file size gives nothing at all.
        write_reg(REG_ORIGINAL_SIZE, 24'd0);
        send_plain(8'h55, 1'b1);
        send_plain(8'h55, 1'b0);
        send_plain(8'h05, 1'b0);
        settle();

        // Directed: raw pass-through, then mode changes in mid-stream.
        write_reg(REG_XOR_KEY, 24'h00);
        write_reg(REG_COMPRESSED_MODE, 24'd0);
        write_reg(REG_ORIGINAL_SIZE, 24'hFFFFFF);
        send_plain(8'h33, 1'b1);
        send_plain(8'h33, 1'b0);
        send_plain(8'hFF, 1'b0);
        send_plain(8'hFF, 1'b0);
        settle();
        write_reg(REG_COMPRESSED_MODE, 24'd1);
        send_plain(8'hFF, 1'b0);
        settle();
        write_reg(REG_COMPRESSED_MODE, 24'd0);
        send_plain(8'h05, 1'b0);
        send_plain(8'h00, 1'b0);
        settle();

        // Random files under rotating idle patterns.
        random_items = items_sent;
        while (items_sent - random_items < 1450)
        begin
            case (files_run % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 75; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            write_reg(REG_XOR_KEY, pick_key());
            len = $urandom_range(10, 60);
            if (files_run == 4)
            begin
                // Long output hold-off while input runs at full rate.
                write_reg(REG_COMPRESSED_MODE, 24'd1);
                write_reg(REG_ORIGINAL_SIZE, 24'hFFFFFF);
                @(posedge clk);
                hold_cycles = 60;
                run_file(80, 1'b1);
            end
            else
            begin
                write_reg(REG_COMPRESSED_MODE, CFG_DATA_W'($urandom_range(3) != 0));
                write_reg(REG_ORIGINAL_SIZE, pick_size());
                if ($urandom_range(4) == 0)
                begin
                    // Flip the mode halfway through the file.
                    run_file(len / 2, 1'b1);
                    settle();
                    write_reg(REG_COMPRESSED_MODE, CFG_DATA_W'(!sb.compressed));
                    run_file(len - len / 2, 1'b0);
                end
                else
                    run_file(len, 1'b1);
            end
            settle();
            files_run++;
        end

        settle();
        $display("Run covered %0d packed bytes in %0d random files plus directed cases.",
                 items_sent, files_run);
        $display("Checked %0d output items, %0d flagged last, longest run %0d copies.",
                 sb.checked, sb.last_seen, sb.longest_run);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xrd_pkg.sv
rtl/xrd_front.sv
rtl/xrd_queue.sv
rtl/xrd_back.sv
rtl/xor_rle_byte_decoder_unit.sv
bench/tb.sv
